FILE: src/rclfr_pkg.sv
// Shared types, constants and CRC function of the RC link frame receiver.
package rclfr_pkg;

   localparam int STORE_BYTES_DEFAULT   = 22;
   localparam int CHANNEL_COUNT_DEFAULT = 16;
   localparam int CHANNEL_BITS          = 11;
   localparam int STATS_COUNT           = 10;

   localparam logic [7:0] RC_MIN_LENGTH    = 8'd24;
   localparam logic [7:0] STATS_MIN_LENGTH = 8'd12;

   localparam logic [7:0]  SYNC_RESET     = 8'd200;
   localparam logic [7:0]  POLY_RESET     = 8'd213;
   localparam logic [7:0]  CHAN_RESET     = 8'd22;
   localparam logic [7:0]  STATS_RESET    = 8'd20;
   localparam logic [15:0] TIMEOUT_RESET  = 16'd250;

   localparam logic [2:0] CSR_SYNC_VALUE      = 3'd0;
   localparam logic [2:0] CSR_CRC_POLYNOMIAL  = 3'd1;
   localparam logic [2:0] CSR_CHANNELS_TYPE   = 3'd2;
   localparam logic [2:0] CSR_LINK_STATS_TYPE = 3'd3;
   localparam logic [2:0] CSR_TIMEOUT_TICKS   = 3'd4;

   localparam logic [1:0] KIND_CHANNEL = 2'd0;
   localparam logic [1:0] KIND_STAT    = 2'd1;
   localparam logic [1:0] KIND_LOST    = 2'd2;

   typedef struct packed {
      logic [7:0]  sync_value;
      logic [7:0]  crc_polynomial;
      logic [7:0]  channels_type;
      logic [7:0]  link_stats_type;
      logic [15:0] timeout_ticks;
   } cfg_type;

   typedef enum logic [1:0] {
      JOB_CHAN,
      JOB_STATS,
      JOB_LOST
   } job_kind_type;

   typedef struct packed {
      logic         start;
      job_kind_type kind;
   } job_type;

   typedef enum logic [1:0] {
      EM_IDLE,
      EM_CHAN,
      EM_STATS,
      EM_LOST
   } em_state_type;

   function automatic logic [7:0] crc_update(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ poly) : (c << 1);
      end
      return c;
   endfunction

endpackage

FILE: src/rclfr_store.sv
// Payload byte memory: one write port, one registered read port.
module rclfr_store #(
   parameter int DEPTH = rclfr_pkg::STORE_BYTES_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/rclfr_parser.sv
// Frame parser: sync, length, type, payload capture, CRC check and idle timer.
module rclfr_parser #(
   parameter int STORE_BYTES = rclfr_pkg::STORE_BYTES_DEFAULT,
   parameter int AW          = $clog2(STORE_BYTES)
) (
   input  logic                clock,
   input  logic                reset,
   input  rclfr_pkg::cfg_type  cfg,
   input  logic                accept,
   input  logic                cmd,
   input  logic [7:0]          rx_byte,
   output logic                wr_en,
   output logic [AW-1:0]       wr_addr,
   output logic [7:0]          wr_data,
   output rclfr_pkg::job_type  job
);

   logic [8:0]  pos_ff, pos_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  crc_ff, crc_in;
   logic [15:0] idle_ff, idle_in;
   logic        lost_ff, lost_in;
   logic [15:0] idle_sat;
   logic [8:0]  pay_pos;

   assign idle_sat = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
   assign pay_pos  = pos_ff - 9'd3;

   always_comb begin
      pos_in    = pos_ff;
      len_in    = len_ff;
      type_in   = type_ff;
      crc_in    = crc_ff;
      idle_in   = idle_ff;
      lost_in   = lost_ff;
      wr_en     = 1'b0;
      wr_addr   = pay_pos[AW-1:0];
      wr_data   = rx_byte;
      job.start = 1'b0;
      job.kind  = rclfr_pkg::JOB_CHAN;
      if (accept && !lost_ff) begin
         if (cmd) begin
            idle_in = idle_sat;
            if (idle_sat > cfg.timeout_ticks) begin
               lost_in   = 1'b1;
               job.start = 1'b1;
               job.kind  = rclfr_pkg::JOB_LOST;
            end
         end else begin
            unique case (pos_ff)
               9'd0: begin
                  if (rx_byte == cfg.sync_value) begin
                     pos_in = 9'd1;
                  end
               end
               9'd1: begin
                  if (rx_byte < 8'd2) begin
                     pos_in = 9'd0;
                  end else begin
                     len_in = rx_byte;
                     pos_in = 9'd2;
                  end
               end
               9'd2: begin
                  type_in = rx_byte;
                  crc_in  = rclfr_pkg::crc_update(8'd0, rx_byte, cfg.crc_polynomial);
                  pos_in  = 9'd3;
                  if (rx_byte == cfg.channels_type) begin
                     idle_in = 16'd0;
                  end
               end
               default: begin
                  if (type_ff == cfg.channels_type) begin
                     idle_in = 16'd0;
                  end
                  if (pos_ff >= ({1'b0, len_ff} + 9'd1)) begin
                     pos_in = 9'd0;
                     if (rx_byte == crc_ff) begin
                        if (type_ff == cfg.channels_type) begin
                           if (len_ff >= rclfr_pkg::RC_MIN_LENGTH) begin
                              job.start = 1'b1;
                              job.kind  = rclfr_pkg::JOB_CHAN;
                           end
                        end else if (type_ff == cfg.link_stats_type) begin
                           if (len_ff >= rclfr_pkg::STATS_MIN_LENGTH) begin
                              job.start = 1'b1;
                              job.kind  = rclfr_pkg::JOB_STATS;
                           end
                        end
                     end
                  end else begin
                     wr_en  = (pay_pos < 9'(STORE_BYTES));
                     crc_in = rclfr_pkg::crc_update(crc_ff, rx_byte, cfg.crc_polynomial);
                     pos_in = pos_ff + 9'd1;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         len_ff  <= '0;
         type_ff <= '0;
         crc_ff  <= '0;
         idle_ff <= '0;
         lost_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         len_ff  <= len_in;
         type_ff <= type_in;
         crc_ff  <= crc_in;
         idle_ff <= idle_in;
         lost_ff <= lost_in;
      end
   end

endmodule

FILE: src/rclfr_emitter.sv
// Result sequencer: reads stored payload, unpacks channels, drives the output register.
module rclfr_emitter #(
   parameter int STORE_BYTES   = rclfr_pkg::STORE_BYTES_DEFAULT,
   parameter int CHANNEL_COUNT = rclfr_pkg::CHANNEL_COUNT_DEFAULT,
   parameter int AW            = $clog2(STORE_BYTES)
) (
   input  logic               clock,
   input  logic               reset,
   input  rclfr_pkg::job_type job,
   output logic               busy,
   output logic               rd_en,
   output logic [AW-1:0]      rd_addr,
   input  logic [7:0]         rd_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic [3:0]         rsp_index,
   output logic [10:0]        rsp_value,
   output logic               rsp_last
);

   localparam int CHAN_BYTES = (CHANNEL_COUNT * rclfr_pkg::CHANNEL_BITS + 7) / 8;
   localparam logic [3:0] LAST_CHAN = 4'(CHANNEL_COUNT - 1);
   localparam logic [3:0] LAST_STAT = 4'(rclfr_pkg::STATS_COUNT - 1);
   localparam logic [4:0] CH_BITS   = 5'(rclfr_pkg::CHANNEL_BITS);

   rclfr_pkg::em_state_type state_ff, state_in;
   logic [AW:0]  addr_ff, addr_in;
   logic [17:0]  acc_ff, acc_in, acc_e, acc_n;
   logic [4:0]   cnt_ff, cnt_in, cnt_e, cnt_n;
   logic [3:0]   idx_ff, idx_in;
   logic         have_ff, have_in;
   logic         out_v_ff, out_v_in;
   logic [1:0]   kind_ff, ld_kind;
   logic [3:0]   index_ff, ld_index;
   logic [10:0]  value_ff, ld_value;
   logic         last_ff, ld_last;
   logic         load;
   logic         slot_free;

   assign slot_free = !out_v_ff || !rsp_stall;
   assign acc_e     = have_ff ? (acc_ff | ({10'd0, rd_data} << cnt_ff)) : acc_ff;
   assign cnt_e     = have_ff ? cnt_ff + 5'd8 : cnt_ff;
   assign busy      = (state_ff != rclfr_pkg::EM_IDLE);
   assign rd_addr   = addr_ff[AW-1:0];

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      have_in  = 1'b0;
      acc_n    = acc_e;
      cnt_n    = cnt_e;
      rd_en    = 1'b0;
      load     = 1'b0;
      ld_kind  = rclfr_pkg::KIND_CHANNEL;
      ld_index = idx_ff;
      ld_value = '0;
      ld_last  = 1'b0;
      unique case (state_ff)
         rclfr_pkg::EM_IDLE: begin
            if (job.start) begin
               unique case (job.kind)
                  rclfr_pkg::JOB_CHAN:  state_in = rclfr_pkg::EM_CHAN;
                  rclfr_pkg::JOB_STATS: state_in = rclfr_pkg::EM_STATS;
                  rclfr_pkg::JOB_LOST:  state_in = rclfr_pkg::EM_LOST;
                  default:              state_in = rclfr_pkg::EM_IDLE;
               endcase
               addr_in = '0;
               acc_in  = '0;
               cnt_in  = '0;
               idx_in  = '0;
            end
         end
         rclfr_pkg::EM_CHAN: begin
            if ((cnt_e >= CH_BITS) && slot_free) begin
               load     = 1'b1;
               ld_kind  = rclfr_pkg::KIND_CHANNEL;
               ld_value = acc_e[10:0];
               ld_last  = (idx_ff == LAST_CHAN);
               acc_n    = acc_e >> rclfr_pkg::CHANNEL_BITS;
               cnt_n    = cnt_e - CH_BITS;
               idx_in   = idx_ff + 4'd1;
               if (ld_last) begin
                  state_in = rclfr_pkg::EM_IDLE;
               end
            end
            acc_in = acc_n;
            cnt_in = cnt_n;
            if (!ld_last && (cnt_n < CH_BITS) && (addr_ff < (AW+1)'(CHAN_BYTES))) begin
               rd_en   = 1'b1;
               have_in = 1'b1;
               addr_in = addr_ff + (AW+1)'(1);
            end
         end
         rclfr_pkg::EM_STATS: begin
            have_in = have_ff;
            if (have_ff && slot_free) begin
               load     = 1'b1;
               ld_kind  = rclfr_pkg::KIND_STAT;
               ld_value = {3'd0, rd_data};
               ld_last  = (idx_ff == LAST_STAT);
               idx_in   = idx_ff + 4'd1;
               have_in  = 1'b0;
               if (ld_last) begin
                  state_in = rclfr_pkg::EM_IDLE;
               end
            end
            if (!have_in && (addr_ff < (AW+1)'(rclfr_pkg::STATS_COUNT))) begin
               rd_en   = 1'b1;
               have_in = 1'b1;
               addr_in = addr_ff + (AW+1)'(1);
            end
         end
         rclfr_pkg::EM_LOST: begin
            if (slot_free) begin
               load     = 1'b1;
               ld_kind  = rclfr_pkg::KIND_LOST;
               ld_index = '0;
               ld_last  = 1'b1;
               state_in = rclfr_pkg::EM_IDLE;
            end
         end
         default: state_in = rclfr_pkg::EM_IDLE;
      endcase
      out_v_in = load ? 1'b1 : (out_v_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rclfr_pkg::EM_IDLE;
         have_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         have_ff  <= have_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      acc_ff  <= acc_in;
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      if (load) begin
         kind_ff  <= ld_kind;
         index_ff <= ld_index;
         value_ff <= ld_value;
         last_ff  <= ld_last;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_kind  = kind_ff;
   assign rsp_index = index_ff;
   assign rsp_value = value_ff;
   assign rsp_last  = last_ff;

endmodule

FILE: src/rc_link_frame_receiver.sv
// Top level of the RC link frame receiver: control registers and block wiring.
//
// Usage: each req_ beat carries either one received UART byte (req_cmd 0) or one
// time tick (req_cmd 1). Bytes are framed by sync, length, type, payload and a
// CRC-8; payload bytes land in a small memory as they arrive.
// A byte or tick that completes no frame and declares no link loss yields no beat.
// A good channels frame yields CHANNEL_COUNT rsp_ beats, unpacked from memory
// through a bit accumulator fed one byte a cycle while the output is not stalled;
// with 16 channels it takes 22 reads, and req_stall holds the input until the
// last beat is loaded. A link statistics frame yields 10 beats, one per cycle
// while the output is not stalled. Link loss yields one beat, then every req_
// beat is dropped.
// req_stall is high while the results of a frame or a link loss are read out;
// rsp_last marks the final beat of a run. A result sits in an output register, so a
// stalled receiver holds it and the sequencer waits; the next input is taken as
// soon as the last result is loaded.
// Reset clears the parser, timer and control registers to their defaults; the
// payload memory is not cleared. csr_ writes are always ready and take effect
// on the next input.
module rc_link_frame_receiver #(
   parameter int STORE_BYTES   = rclfr_pkg::STORE_BYTES_DEFAULT,
   parameter int CHANNEL_COUNT = rclfr_pkg::CHANNEL_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [3:0]  rsp_index,
   output logic [10:0] rsp_value,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int AW = $clog2(STORE_BYTES);

   rclfr_pkg::cfg_type cfg_ff, cfg_in;
   rclfr_pkg::job_type job;
   logic          accept;
   logic          busy;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   assign csr_ready = 1'b1;
   assign req_stall = busy;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rclfr_pkg::CSR_SYNC_VALUE:      cfg_in.sync_value      = csr_data[7:0];
            rclfr_pkg::CSR_CRC_POLYNOMIAL:  cfg_in.crc_polynomial  = csr_data[7:0];
            rclfr_pkg::CSR_CHANNELS_TYPE:   cfg_in.channels_type   = csr_data[7:0];
            rclfr_pkg::CSR_LINK_STATS_TYPE: cfg_in.link_stats_type = csr_data[7:0];
            rclfr_pkg::CSR_TIMEOUT_TICKS:   cfg_in.timeout_ticks   = csr_data;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_value      <= rclfr_pkg::SYNC_RESET;
         cfg_ff.crc_polynomial  <= rclfr_pkg::POLY_RESET;
         cfg_ff.channels_type   <= rclfr_pkg::CHAN_RESET;
         cfg_ff.link_stats_type <= rclfr_pkg::STATS_RESET;
         cfg_ff.timeout_ticks   <= rclfr_pkg::TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rclfr_parser #(
      .STORE_BYTES (STORE_BYTES),
      .AW          (AW)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .accept  (accept),
      .cmd     (req_cmd),
      .rx_byte (req_rx_byte),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .job     (job)
   );

   rclfr_store #(
      .DEPTH (STORE_BYTES),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rclfr_emitter #(
      .STORE_BYTES   (STORE_BYTES),
      .CHANNEL_COUNT (CHANNEL_COUNT),
      .AW            (AW)
   ) u_emitter (
      .clock     (clock),
      .reset     (reset),
      .job       (job),
      .busy      (busy),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_kind  (rsp_kind),
      .rsp_index (rsp_index),
      .rsp_value (rsp_value),
      .rsp_last  (rsp_last)
   );

endmodule

FILE: src/rclfr_checker.sv
// Port-level checks on the result channel of the RC link frame receiver.
module rclfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [3:0]  rsp_index,
   input logic [10:0] rsp_value,
   input logic        rsp_last
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_index)
                                 && $stable(rsp_value) && $stable(rsp_last))
      else $error("stalled result beat changed");

   a_lost_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == rclfr_pkg::KIND_LOST) |->
         (rsp_index == 4'd0) && (rsp_value == 11'd0) && rsp_last)
      else $error("link lost beat malformed");

   a_stat_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == rclfr_pkg::KIND_STAT) |->
         (rsp_value[10:8] == 3'd0) && (rsp_index < 4'd10)
         && (rsp_last == (rsp_index == 4'd9)))
      else $error("statistic beat malformed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind rc_link_frame_receiver rclfr_checker u_rclfr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_kind  (rsp_kind),
   .rsp_index (rsp_index),
   .rsp_value (rsp_value),
   .rsp_last  (rsp_last)
);
